// ===== src/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
// Used by pba_word_scan and page_bitmap_allocator; no dependencies.
package pba_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } pba_state_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_PHYS_BASE  = 1'b0;
  localparam logic REG_PAGE_LIMIT = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_FREE  = 2'd1;
  localparam logic [1:0] STAT_BAD_ADDR = 2'd2;

  localparam logic [31:0] BASE_MASK       = 32'hFFFF_F000;
  localparam logic [31:0] WORD_ALL_USED   = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [15:0] PAGE_LIMIT_RST  = 16'd32768;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } scan_res_t;

endpackage

// ===== src/page_bitmap_allocator.sv =====
// A free, or an allocate that finds its next free page in the same word, passes from IDLE through
// MODIFY and DONE into the output register; each further word searched adds a pass through SCAN.
// Rejected items (nothing free, address out of range) go from IDLE straight to DONE. A new item is
// taken once the previous result is in the output register, so items are never overlapped.
// After reset the block fills all PAGE_COUNT/32 bitmap words with ones before taking items.
module page_bitmap_allocator #(
  parameter int PAGE_COUNT = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_page_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_alloc_addr,
  output logic [1:0]  out_status,
  output logic [15:0] out_free_pages
);
  import pba_pkg::*;

  localparam int MAP_WORDS = PAGE_COUNT / 32;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW = AW + 5;
  localparam int HW = IW + 1;

  pba_state_t  state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] pg_r, pg_nxt;
  logic          cmd_r, cmd_nxt;
  logic [AW-1:0] scan_w_r, scan_w_nxt;
  logic [HW-1:0] hint_r, hint_nxt;
  logic [15:0]   count_r, count_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_free_r, out_free_nxt;
  logic [31:0]   phys_base_r;
  logic [15:0]   page_limit_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic [HW-1:0] eff_lim;
  logic [31:0]   base;
  logic [31:0]   free_off;
  logic [19:0]   free_pg;
  logic          free_bad;
  logic          accept;
  logic          out_free_slot;

  logic [AW-1:0] cur_w;
  logic [HW-1:0] word_end;
  logic          lim_full, lim_last;
  logic [31:0]   lim_mask, low_mask, page_bit, scan_word, skip_mask;
  scan_res_t     scan_res;

  assign eff_lim = ({16'b0, page_limit_r} < 32'(PAGE_COUNT)) ? HW'(page_limit_r)
                                                             : HW'(PAGE_COUNT);
  assign base     = phys_base_r & BASE_MASK;
  assign free_off = in_page_addr - base;
  assign free_pg  = free_off[31:12];
  assign free_bad = (in_page_addr < base) ||
                    ({12'b0, free_pg} >= 32'(eff_lim));
  assign accept   = in_valid && in_ready;
  assign out_free_slot = !out_valid_r || out_ready;

  assign cur_w     = (state_r == ST_SCAN) ? scan_w_r : pg_r[IW-1:5];
  assign word_end  = {1'b0, cur_w, 5'b0} + HW'(32);
  assign lim_full  = word_end <= eff_lim;
  assign lim_last  = word_end >= eff_lim;
  assign lim_mask  = lim_full ? 32'b0 : (WORD_ALL_USED << eff_lim[4:0]);
  assign low_mask  = ~(32'hFFFF_FFFE << pg_r[4:0]);
  assign page_bit  = 32'd1 << pg_r[4:0];
  assign scan_word = (state_r == ST_MODIFY) ? (mem_rdata | page_bit) : mem_rdata;
  assign skip_mask = (state_r == ST_MODIFY) ? (lim_mask | low_mask) : lim_mask;

  pba_word_scan u_scan (
    .word_i      (scan_word),
    .skip_mask_i (skip_mask),
    .res_o       (scan_res)
  );

  pba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ALLOC) begin
            state_nxt = (hint_r >= eff_lim) ? ST_DONE : ST_MODIFY;
          end else begin
            state_nxt = free_bad ? ST_DONE : ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        if (cmd_r == CMD_FREE || scan_res.found || lim_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.found || lim_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    pg_nxt         = pg_r;
    cmd_nxt        = cmd_r;
    scan_w_nxt     = scan_w_r;
    hint_nxt       = hint_r;
    count_nxt      = count_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_w;
    mem_wdata      = mem_rdata;
    mem_raddr      = cur_w + AW'(1);
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = WORD_ALL_USED;
        clr_nxt   = clr_r + AW'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd_nxt  = in_cmd;
        res_addr_nxt = '0;
        if (in_cmd == CMD_ALLOC) begin
          pg_nxt    = hint_r[IW-1:0];
          mem_raddr = hint_r[IW-1:5];
          res_status_nxt = (hint_r >= eff_lim) ? STAT_NO_FREE : STAT_OK;
        end else begin
          pg_nxt    = free_pg[IW-1:0];
          mem_raddr = free_pg[IW-1:5];
          res_status_nxt = free_bad ? STAT_BAD_ADDR : STAT_OK;
        end
      end
      ST_MODIFY: begin
        if (cmd_r == CMD_ALLOC) begin
          mem_we       = 1'b1;
          mem_wdata    = mem_rdata | page_bit;
          count_nxt    = (count_r != '0) ? count_r - 16'd1 : count_r;
          res_addr_nxt = base + 32'({pg_r, 12'b0});
          scan_w_nxt   = cur_w + AW'(1);
          if (scan_res.found) begin
            hint_nxt = {1'b0, cur_w, scan_res.idx};
          end else if (lim_last) begin
            hint_nxt = HW'(PAGE_COUNT);
          end
        end else if ((mem_rdata & page_bit) == 32'b0) begin
          res_status_nxt = STAT_BAD_ADDR;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~page_bit;
          count_nxt = (count_r != COUNT_MAX) ? count_r + 16'd1 : count_r;
          if (hint_r > {1'b0, pg_r}) begin
            hint_nxt = {1'b0, pg_r};
          end
        end
      end
      ST_SCAN: begin
        scan_w_nxt = cur_w + AW'(1);
        if (scan_res.found) begin
          hint_nxt = {1'b0, cur_w, scan_res.idx};
        end else if (lim_last) begin
          hint_nxt = HW'(PAGE_COUNT);
        end
      end
      ST_DONE: begin
        if (out_free_slot) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = count_r;
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      hint_r       <= HW'(PAGE_COUNT);
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      phys_base_r  <= '0;
      page_limit_r <= PAGE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_PHYS_BASE) begin
        phys_base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_PAGE_LIMIT) begin
        page_limit_r <= cfg_wdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pg_r         <= pg_nxt;
    cmd_r        <= cmd_nxt;
    scan_w_r     <= scan_w_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_status_r;
  assign out_free_pages = out_free_r;

endmodule

// ===== src/pba_word_scan.sv =====
// Finds the lowest free page bit in one bitmap word, skipping masked bits.
// Depends on pba_pkg for the scan result type.
module pba_word_scan (
  input  logic [31:0]          word_i,
  input  logic [31:0]          skip_mask_i,
  output pba_pkg::scan_res_t   res_o
);
  import pba_pkg::*;

  logic [31:0] open_bits;

  assign open_bits = ~(word_i | skip_mask_i);

  always_comb begin
    res_o.found = |open_bits;
    res_o.idx   = '0;
    for (int b = 31; b >= 0; b--) begin
      if (open_bits[b]) begin
        res_o.idx = 5'(b);
      end
    end
  end

endmodule

// ===== src/pba_map_ram.sv =====
// Used-bit map storage: one write port and one read port with registered read data.
// No package dependencies.
module pba_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
